>>> src/deq_pkg.sv
// shared types and codes of the double-ended queue
package deq_pkg;

  localparam int unsigned DEQ_DEPTH = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;

  // command codes at the input
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_ALL   = 3'd4;

  // status codes of a result
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_READ_ALL
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic signed [DATA_W-1:0]  value;
  } deq_item_t;

endpackage

>>> src/deq_front.sv
// command decode and two-entry command queue toward the execution side
module deq_front import deq_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic signed [DATA_W-1:0]  value_i,
  output logic                      busy_o,
  output logic                      item_valid_o,
  output deq_item_t                 item_o,
  input  logic                      item_pop_i
);

  localparam int unsigned QD = 2;

  deq_item_t         item_q [QD];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              known;
  op_e               op;
  logic              push;
  logic              pop;

  // decode, unknown codes are taken and dropped
  always_comb begin
    known = 1'b1;
    op    = OP_PUSH_FRONT;
    case (cmd_i)
      CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  op = OP_PUSH_BACK;
      CMD_POP_BACK:   op = OP_POP_BACK;
      CMD_POP_FRONT:  op = OP_POP_FRONT;
      CMD_READ_ALL:   op = OP_READ_ALL;
      default:        known = 1'b0;
    endcase
  end

  assign busy_o       = (cnt_q == 2'(QD));
  assign push         = start_i && !busy_o && known;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = item_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= '{op: op, value: value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> src/deq_back.sv
// ring store with head index and count, executes queued commands
module deq_back import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  deq_item_t                 item_i,
  output logic                      item_pop_o,
  output logic                      valid_o,
  output logic signed [DATA_W-1:0]  entry_value_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic                      last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X   = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  typedef enum logic {S_IDLE, S_WALK} state_e;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                stat_vld_q, stat_vld_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic                rd_vld_q, rd_vld_d;
  logic                rd_last_q, rd_last_d;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                full;
  logic                empty;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       head_inc;
  logic                walk_last;

  // ring position of base + off, both below the depth
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_X) sum = sum - DEPTH_X;
    return sum[AW-1:0];
  endfunction

  assign full      = (count_q == FULL_CNT);
  assign empty     = (count_q == '0);
  assign head_dec  = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
  assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign rd_addr   = slot_of(head_q, idx_q);
  assign walk_last = ((CW'(idx_q) + 1'b1) == count_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    stat_vld_d = 1'b0;
    stat_d     = STATUS_OK;
    rd_vld_d   = 1'b0;
    rd_last_d  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head_dec;
    rd_en      = 1'b0;
    item_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          case (item_i.op)
            OP_PUSH_FRONT: begin
              stat_vld_d = 1'b1;
              if (full) begin
                stat_d = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = head_dec;
                head_d  = head_dec;
                count_d = count_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              stat_vld_d = 1'b1;
              if (full) begin
                stat_d = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = slot_of(head_q, count_q[AW-1:0]);
                count_d = count_q + 1'b1;
              end
            end
            OP_POP_BACK: begin
              stat_vld_d = 1'b1;
              if (empty) begin
                stat_d = STATUS_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            OP_POP_FRONT: begin
              stat_vld_d = 1'b1;
              if (empty) begin
                stat_d = STATUS_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - 1'b1;
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                stat_vld_d = 1'b1;
                stat_d     = STATUS_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        rd_en     = 1'b1;
        rd_vld_d  = 1'b1;
        rd_last_d = walk_last;
        if (walk_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= item_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      stat_vld_q <= 1'b0;
      stat_q     <= STATUS_OK;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      stat_vld_q <= stat_vld_d;
      stat_q     <= stat_d;
      rd_vld_q   <= rd_vld_d;
      rd_last_q  <= rd_last_d;
    end
  end

  assign valid_o       = stat_vld_q || rd_vld_q;
  assign entry_value_o = rd_vld_q ? rd_data_q : '0;
  assign status_o      = rd_vld_q ? STATUS_OK : stat_q;
  assign last_o        = rd_vld_q ? rd_last_q : 1'b1;

endmodule

>>> src/double_ended_queue_ring.sv
// top level of the bounded double-ended queue on a ring store
//
// a command transfer happens at a rising edge with start_i high and busy_o
// low; each result is shown for exactly one cycle with valid_o high and must
// be taken then, the receiver has no way to stall it. commands go into a
// two-entry queue in the front part; the back part owns the ring store,
// head index and count. a command is written into the front queue at the
// transfer edge; a free back part takes a push or pop from there and
// registers its status result, shown on the ports in the cycle after the
// back part takes it. a read-out of n entries is dispatched, then reads one
// store entry per cycle through the single read port and gives n results,
// one per cycle, last_o on the final one; a read-out of an empty queue
// gives one result with empty status. busy_o rises only when both queue
// entries are taken, i.e. while a read-out walk holds the back part.
// unknown command codes are taken and dropped with no result. the store
// has no reset; only written entries are ever read
module double_ended_queue_ring import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command transfer
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic signed [DATA_W-1:0]  value_i,
  // result transfer, each result shown for a single cycle
  output logic                      valid_o,
  output logic signed [DATA_W-1:0]  entry_value_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic                      last_o
);

  // queued command from front to back
  logic      item_valid;
  deq_item_t item;
  logic      item_pop;

  // decode and buffer
  deq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .busy_o       (busy_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // execute against the ring store
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .valid_o       (valid_o),
    .entry_value_o (entry_value_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

>>> dv/double_ended_queue_ring_checker.sv
`timescale 1ns / 1ps
// checker that predicts and compares the results of the double-ended queue
module double_ended_queue_ring_checker import deq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic [STATUS_W-1:0]      status_i,
  input  logic                     last_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              awaited_count_o,
  output int unsigned              checked_count_o,
  output int unsigned              full_refusals_o,
  output int unsigned              empty_reports_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] entry_value;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } deq_result_t;

  // shadow copy of the ring, front slot and fill level
  logic signed [DATA_W-1:0] ring_words [DEQ_DEPTH];
  int unsigned              front_slot;
  int unsigned              fill_level;
  deq_result_t              awaited_results [$];

  task automatic flag_mismatch(input string text);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t: %s", $time, text);
    end
  endtask

  // applies one accepted command to the shadow queue and queues its results
  function automatic void predict_command(input logic [CMD_W-1:0]         cmd,
                                          input logic signed [DATA_W-1:0] value);
    deq_result_t res;
    res = '0;
    res.last = 1'b1;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_level >= DEQ_DEPTH) begin
          res.status = STATUS_FULL;
          full_refusals_o++;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            front_slot = (front_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
            ring_words[front_slot] = value;
          end else begin
            ring_words[(front_slot + fill_level) % DEQ_DEPTH] = value;
          end
          fill_level++;
          res.status = STATUS_OK;
        end
        awaited_results.push_back(res);
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (fill_level == 0) begin
          res.status = STATUS_EMPTY;
          empty_reports_o++;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            front_slot = (front_slot + 1) % DEQ_DEPTH;
          end
          fill_level--;
          res.status = STATUS_OK;
        end
        awaited_results.push_back(res);
      end
      CMD_READ_ALL: begin
        if (fill_level == 0) begin
          res.status = STATUS_EMPTY;
          empty_reports_o++;
          awaited_results.push_back(res);
        end else begin
          // walk from the front, wrapping around the ring
          for (int unsigned k = 0; k < fill_level; k++) begin
            res.entry_value = ring_words[(front_slot + k) % DEQ_DEPTH];
            res.status      = STATUS_OK;
            res.last        = (k + 1 == fill_level);
            awaited_results.push_back(res);
          end
        end
      end
      default: ; // unknown codes are dropped without a result
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deq_result_t want;
    if (!rst_ni) begin
      front_slot       = 0;
      fill_level       = 0;
      awaited_results.delete();
      mismatch_count_o = 0;
      checked_count_o  = 0;
      full_refusals_o  = 0;
      empty_reports_o  = 0;
      awaited_count_o  = 0;
    end else begin
      // results always belong to earlier transfers, so check before predicting
      if (valid_i) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing awaited: value %0d status %0d last %0b",
                                  entry_value_i, status_i, last_i));
        end else begin
          want = awaited_results.pop_front();
          checked_count_o++;
          if (want.entry_value !== entry_value_i || want.status !== status_i ||
              want.last !== last_i) begin
            flag_mismatch($sformatf({"expected value %0d status %0d last %0b, ",
                                     "got value %0d status %0d last %0b"},
                                    want.entry_value, want.status, want.last,
                                    entry_value_i, status_i, last_i));
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_command(cmd_i, value_i);
      end
      awaited_count_o = awaited_results.size();
    end
  end

endmodule

>>> dv/double_ended_queue_ring_tb.sv
`timescale 1ns / 1ps
// testbench top for the double-ended queue: stimulus, checker hookup and verdict
module double_ended_queue_ring_tb import deq_pkg::*;;

  localparam int unsigned          RANDOM_ITEMS    = 95;
  localparam int unsigned          DRAIN_CYCLES    = 40;
  localparam int unsigned          LIMIT_CYCLES    = 100000;
  localparam logic [CMD_W-1:0]     CMD_UNKNOWN_TOP = '1;
  localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk_i   = 1'b0;
  logic                     rst_ni;
  logic                     start_i = 1'b0;
  logic [CMD_W-1:0]         cmd_i   = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     busy_o;
  logic                     valid_o;
  logic signed [DATA_W-1:0] entry_value_o;
  logic [STATUS_W-1:0]      status_o;
  logic                     last_o;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned checked_count;
  int unsigned full_refusals;
  int unsigned empty_reports;
  int unsigned commands_sent;
  int unsigned zero_gap_run;

  always #4 clk_i = ~clk_i;

  double_ended_queue_ring DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .entry_value_o (entry_value_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  double_ended_queue_ring_checker result_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .cmd_i            (cmd_i),
    .value_i          (value_i),
    .valid_i          (valid_o),
    .entry_value_i    (entry_value_o),
    .status_i         (status_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count),
    .checked_count_o  (checked_count),
    .full_refusals_o  (full_refusals),
    .empty_reports_o  (empty_reports)
  );

  // mostly random words, with the sign extremes, zero and minus one mixed in
  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 11))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // one command transfer, preceded by a random idle gap; runs of zero gaps keep
  // start high across several transfers
  task automatic send_command(input logic [CMD_W-1:0]         cmd,
                              input logic signed [DATA_W-1:0] value);
    int unsigned gap;
    bit          taken;
    if (zero_gap_run > 0) begin
      gap = 0;
      zero_gap_run--;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = 0;
      zero_gap_run = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(0, 15);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= cmd;
    value_i <= value;
    // busy is stable at the falling edge, so look there and take the next rise
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    commands_sent++;
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    int unsigned      pick;
    int unsigned      real_items;
    bit               grow_phase;

    commands_sent = 0;
    zero_gap_run  = 0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: read-out and both pops report empty, unknown code is dropped
    send_command(CMD_READ_ALL, '0);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '1);
    send_command(CMD_UNKNOWN_TOP, '1);

    // extremes at both ends, front pushes wrap the head below slot zero
    send_command(CMD_PUSH_FRONT, MOST_NEGATIVE);
    send_command(CMD_PUSH_BACK, MOST_POSITIVE);
    send_command(CMD_PUSH_FRONT, '1);
    send_command(CMD_PUSH_BACK, '0);
    for (int k = 0; k < DEQ_DEPTH - 4; k++) begin
      send_command(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom());
    end

    // full queue: both pushes refused, then a read-out across the wrap
    send_command(CMD_PUSH_BACK, draw_value());
    send_command(CMD_PUSH_FRONT, draw_value());
    send_command(CMD_READ_ALL, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);

    // random walk: alternating grow and shrink phases so the queue keeps
    // hitting both full and empty, with read-outs and unknown codes sprinkled in
    real_items = 0;
    grow_phase = 1'b0;
    while (real_items < RANDOM_ITEMS) begin
      if (real_items % 18 == 0) begin
        grow_phase = ~grow_phase;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        cmd = CMD_W'($urandom_range(CMD_READ_ALL + 1, CMD_UNKNOWN_TOP));
      end else if (pick < 16) begin
        cmd = CMD_READ_ALL;
      end else if (pick < (grow_phase ? 86 : 30)) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end
      send_command(cmd, draw_value());
      if (cmd <= CMD_READ_ALL) begin
        real_items++;
      end
    end
    start_i <= 1'b0;

    // let every awaited result arrive, then give the block time to go quiet
    @(negedge clk_i);
    while (awaited_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d command transfers sent, %0d results checked", commands_sent,
             checked_count);
    $display("%0d pushes refused on a full queue, %0d empty reports", full_refusals,
             empty_reports);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: a hung handshake or a missing result ends the run here
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("cycle limit reached with %0d results still awaited", awaited_count);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
src/deq_pkg.sv
src/deq_front.sv
src/deq_back.sv
src/double_ended_queue_ring.sv
dv/double_ended_queue_ring_checker.sv
dv/double_ended_queue_ring_tb.sv
